[rtl/crcw_pkg.sv]
package crcw_pkg;

    localparam int CRCW_WORD_BITS = 64;
    localparam int CRCW_CRC_BITS  = 32;
    localparam int CRCW_LANE_BITS = 8;
    localparam int CRCW_LANES     = CRCW_WORD_BITS / CRCW_LANE_BITS;

    localparam logic [CRCW_CRC_BITS-1:0] CRCW_POLY     = 32'h82F6_3B78;
    localparam logic [CRCW_CRC_BITS-1:0] CRCW_RESET_CRC = 32'hFFFF_FFFF;

    typedef logic [CRCW_CRC_BITS-1:0] crc_t;
    typedef logic [CRCW_WORD_BITS-1:0][CRCW_CRC_BITS-1:0] col_tab_t;
    typedef logic [CRCW_LANES-1:0][CRCW_CRC_BITS-1:0] lane_parts_t;

    // Word in the first stage handed to the merge stage.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        crc_t seed_part;
    } crcw_s1_t;

    // Column p is the 64-bit bit-serial update applied to a word with only bit p set.
    // Evaluated once at elaboration.
    function automatic col_tab_t crcw_make_columns();
        col_tab_t                  tab;
        logic [CRCW_WORD_BITS-1:0] x;
        for (int p = 0; p < CRCW_WORD_BITS; p++)
        begin
            x = {{(CRCW_WORD_BITS-1){1'b0}}, 1'b1} << p;
            for (int i = 0; i < CRCW_WORD_BITS; i++)
            begin
                if (x[0])
                    x = (x >> 1) ^ {{(CRCW_WORD_BITS-CRCW_CRC_BITS){1'b0}}, CRCW_POLY};
                else
                    x = x >> 1;
            end
            tab[p] = x[CRCW_CRC_BITS-1:0];
        end
        return tab;
    endfunction

    localparam col_tab_t CRCW_COLS = crcw_make_columns();

    // Contribution of a 32-bit register value, which sits in the low bits of the word.
    function automatic crc_t crcw_fold_reg(input crc_t r);
        crc_t acc;
        acc = '0;
        for (int j = 0; j < CRCW_CRC_BITS; j++)
        begin
            if (r[j])
                acc = acc ^ CRCW_COLS[j];
        end
        return acc;
    endfunction

endpackage

[rtl/crcw_lane.sv]
module crcw_lane #(
    parameter int LANE_IDX = 0
) (
    input  logic                                   clk,
    input  logic                                   load,
    input  logic [crcw_pkg::CRCW_LANE_BITS-1:0]    lane_byte,
    output crcw_pkg::crc_t                         part
);
    import crcw_pkg::*;

    crc_t part_reg;
    crc_t part_next;

    // Each byte bit selects the column for its place in the word.
    always_comb
    begin
        part_next = '0;
        for (int j = 0; j < CRCW_LANE_BITS; j++)
        begin
            if (lane_byte[j])
                part_next = part_next ^ CRCW_COLS[LANE_IDX*CRCW_LANE_BITS + j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            part_reg <= part_next;
    end

    assign part = part_reg;

endmodule

[rtl/crcw_merge.sv]
module crcw_merge (
    input  logic                   clk,
    input  logic                   rst_n,
    input  crcw_pkg::crcw_s1_t     s1,
    input  crcw_pkg::lane_parts_t  lane_parts,
    output logic                   s1_go,
    output logic                   crc_valid,
    input  logic                   crc_stall,
    output crcw_pkg::crc_t         crc_raw
);
    import crcw_pkg::*;

    crc_t crc_reg;
    crc_t crc_next;
    crc_t data_part;
    logic out_valid_reg;
    logic out_valid_next;
    crc_t out_crc_reg;

    always_comb
    begin
        data_part = '0;
        for (int k = 0; k < CRCW_LANES; k++)
        begin
            data_part = data_part ^ lane_parts[k];
        end
    end

    // A first word starts from the inverted seed, whose contribution was formed a stage earlier.
    assign crc_next = (s1.first ? s1.seed_part : crcw_fold_reg(crc_reg)) ^ data_part;

    // A non-final word may always move on; a final word needs a free output register.
    assign s1_go = s1.valid && (!s1.last || !out_valid_reg || !crc_stall);

    always_comb
    begin
        if (s1_go && s1.last)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && crc_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= CRCW_RESET_CRC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_go)
                crc_reg <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1.last)
            out_crc_reg <= crc_next;
    end

    assign crc_valid = out_valid_reg;
    assign crc_raw   = out_crc_reg;

    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && s1.last) |=> out_valid_reg)
        else $error("final word did not produce a result");

    a_emit_matches_reg: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && s1.last) |=> (out_crc_reg == crc_reg))
        else $error("emitted CRC differs from running register");

    a_idle_holds_reg: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_go |=> $stable(crc_reg))
        else $error("CRC register changed without a word");

    a_held_result_blocks_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && crc_stall && s1.valid && s1.last) |-> !s1_go)
        else $error("final word overwrote a result still waiting");

endmodule

[rtl/crc32c_wide_stream.sv]
// Reflected CRC-32C (Castagnoli, polynomial 0x82F63B78) over a stream of 64-bit words, eight
// message bytes per word with the first byte in bits 7 to 0. A word marked first_word loads the
// register with the inverse of seed_crc (zero for a fresh message, or a finished CRC to chain),
// and a word marked last_word yields one result, crc_raw, which is the register after that word
// without the final inversion; invert it to obtain the usual finished CRC. Words with neither
// mark continue from the current register, which after reset is all ones. The block takes one
// word per clock cycle while no held result stalls it. A word is registered in the first
// stage, eight byte lanes, each folding its byte into a 32-bit partial remainder, and the
// second stage XORs the lane results with the register's own contribution in a single
// 32-bit feedback step, which is the loop that sets the clock rate, and writes a final
// word's result to the output register. That register holds a result that is stalled, and
// the input keeps taking words until a second final word would have to overwrite it.
module crc32c_wide_stream (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 word_valid,
    output logic                                 word_stall,
    input  logic [crcw_pkg::CRCW_WORD_BITS-1:0]  data_word,
    input  logic                                 first_word,
    input  logic                                 last_word,
    input  logic [crcw_pkg::CRCW_CRC_BITS-1:0]   seed_crc,
    output logic                                 crc_valid,
    input  logic                                 crc_stall,
    output logic [crcw_pkg::CRCW_CRC_BITS-1:0]   crc_raw
);
    import crcw_pkg::*;

    logic        accept;
    logic        s1_go;
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        s1_first_reg;
    logic        s1_last_reg;
    crc_t        seed_part_reg;
    crcw_s1_t    s1;
    lane_parts_t lane_parts;

    // The first stage can take a word when it is empty or its word moves on this cycle.
    assign word_stall = s1_valid_reg && !s1_go;
    assign accept     = word_valid && !word_stall;

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    // The seed's contribution is formed alongside the lanes so that the
    // feedback step only has to pick it.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_first_reg  <= first_word;
            s1_last_reg   <= last_word;
            seed_part_reg <= crcw_fold_reg(~seed_crc);
        end
    end

    genvar k;
    generate
        for (k = 0; k < CRCW_LANES; k++)
        begin : g_lane
            crcw_lane #(
                .LANE_IDX (k)
            ) u_lane (
                .clk       (clk),
                .load      (accept),
                .lane_byte (data_word[k*CRCW_LANE_BITS +: CRCW_LANE_BITS]),
                .part      (lane_parts[k])
            );
        end
    endgenerate

    assign s1.valid     = s1_valid_reg;
    assign s1.first     = s1_first_reg;
    assign s1.last      = s1_last_reg;
    assign s1.seed_part = seed_part_reg;

    crcw_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1         (s1),
        .lane_parts (lane_parts),
        .s1_go      (s1_go),
        .crc_valid  (crc_valid),
        .crc_stall  (crc_stall),
        .crc_raw    (crc_raw)
    );

endmodule
